// ===== hw/rtl/tmfd_pkg.sv =====
package tmfd_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int SAMPLE_LSB = 4;
  localparam int TERM_W     = 9;
  localparam int GRP        = 8;
  localparam int GRP_W      = 12;
  localparam int QUAD       = 4;
  localparam int QUAD_W     = 14;
  localparam int SUM_W      = 16;
  localparam int KEY_W      = 128;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic signed [SUM_W-1:0] THRESHOLD_RESET = 16'sd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_KEY_LOW   = 2'd1,
    REG_KEY_HIGH  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] raw_sample;
    logic        frame_start;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] correlation;
    logic                    hit;
    logic                    detected;
  } out_t;

  typedef struct packed {
    logic vld;
    logic fs;
  } tag_t;

endpackage

// ===== hw/rtl/tmfd_cell.sv =====
module tmfd_cell
  import tmfd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift_en,
  input  logic                     clr,
  input  logic                     sign,
  input  logic [SAMPLE_W-1:0]      din,
  output logic [SAMPLE_W-1:0]      dout,
  output logic signed [TERM_W-1:0] term
);

  logic [SAMPLE_W-1:0]      even_r;
  logic [SAMPLE_W-1:0]      odd_r;
  logic signed [TERM_W-1:0] mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      even_r <= '0;
      odd_r  <= '0;
    end else if (shift_en) begin
      even_r <= din;
      odd_r  <= clr ? '0 : even_r;
    end
  end

  always_comb begin
    mag  = signed'({1'b0, even_r});
    term = sign ? mag : -mag;
  end

  assign dout = odd_r;

endmodule

// ===== hw/rtl/tmfd_sum.sv =====
module tmfd_sum
  import tmfd_pkg::*;
#(
  parameter int NCELL = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  tag_t                     tag_in,
  input  logic signed [TERM_W-1:0] terms [NCELL],
  output tag_t                     tag_out,
  output logic signed [SUM_W-1:0]  sum
);

  localparam int NGRP  = (NCELL + GRP - 1) / GRP;
  localparam int NQUAD = (NGRP + QUAD - 1) / QUAD;

  logic signed [TERM_W-1:0] terms_pad [NGRP*GRP];
  logic signed [GRP_W-1:0]  grp_nxt   [NGRP];
  logic signed [GRP_W-1:0]  grp_r     [NGRP];
  logic signed [GRP_W-1:0]  grp_pad   [NQUAD*QUAD];
  logic signed [QUAD_W-1:0] quad_nxt  [NQUAD];
  logic signed [QUAD_W-1:0] quad_r    [NQUAD];
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  sum_r;
  tag_t                     t1_r, t2_r, t3_r;

  for (genvar i = 0; i < NGRP*GRP; i++) begin : g_tpad
    if (i < NCELL) begin : g_t
      assign terms_pad[i] = terms[i];
    end else begin : g_z
      assign terms_pad[i] = '0;
    end
  end

  for (genvar i = 0; i < NQUAD*QUAD; i++) begin : g_gpad
    if (i < NGRP) begin : g_g
      assign grp_pad[i] = grp_r[i];
    end else begin : g_z
      assign grp_pad[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int i = 0; i < GRP; i++) begin
        grp_nxt[g] = grp_nxt[g] + GRP_W'(terms_pad[g*GRP + i]);
      end
    end
    for (int q = 0; q < NQUAD; q++) begin
      quad_nxt[q] = '0;
      for (int i = 0; i < QUAD; i++) begin
        quad_nxt[q] = quad_nxt[q] + QUAD_W'(grp_pad[q*QUAD + i]);
      end
    end
    sum_nxt = '0;
    for (int q = 0; q < NQUAD; q++) begin
      sum_nxt = sum_nxt + SUM_W'(quad_r[q]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
    end else if (adv) begin
      t1_r <= tag_in;
      t2_r <= t1_r;
      t3_r <= t2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp_r  <= grp_nxt;
      quad_r <= quad_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign tag_out = t3_r;
  assign sum     = sum_r;

endmodule

// ===== hw/rtl/ternary_matched_filter_detector.sv =====
// Streaming matched filter: each transfer carries one ADC word, whose bits 11:4 form an
// unsigned 8-bit sample, and yields one result with the signed correlation of the last
// TAPS samples against the +1/-1 key on the even taps, a hit flag (sum strictly above
// the signed threshold) and a detection flag that stays set from the first hit until
// the next frame start. The block takes one sample per cycle while the output is not
// stalled; each sample passes through the row of tap cells, three registered adder-tree
// stages and the output register. Threshold and key registers are meant to be written
// only while no result is outstanding.
module ternary_matched_filter_detector
  import tmfd_pkg::*;
#(
  parameter int TAPS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NCELL = (TAPS + 1) / 2;

  logic signed [SUM_W-1:0]  thr_r;
  logic [CFG_DATA_W-1:0]    key_low_r;
  logic [CFG_DATA_W-1:0]    key_high_r;
  logic [KEY_W-1:0]         keys;

  logic                     adv;
  logic                     accept;
  logic [SAMPLE_W-1:0]      cur;
  logic [SAMPLE_W-1:0]      din  [NCELL];
  logic [SAMPLE_W-1:0]      dout [NCELL];
  logic signed [TERM_W-1:0] terms [NCELL];

  tag_t                     t0_r;
  tag_t                     t3;
  logic signed [SUM_W-1:0]  sum;

  logic                     out_valid_r;
  out_t                     out_data_r;
  logic                     latch_r;
  logic                     hit;
  logic                     det;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign cur      = in_data.raw_sample[SAMPLE_LSB +: SAMPLE_W];
  assign keys     = {key_high_r, key_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THRESHOLD_RESET;
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_THRESHOLD: thr_r      <= cfg_wdata[SUM_W-1:0];
        REG_KEY_LOW:   key_low_r  <= cfg_wdata;
        REG_KEY_HIGH:  key_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    if (j == 0) begin : g_first
      assign din[j] = cur;
    end else begin : g_rest
      assign din[j] = in_data.frame_start ? '0 : dout[j-1];
    end

    tmfd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .clr      (in_data.frame_start),
      .sign     (keys[j]),
      .din      (din[j]),
      .dout     (dout[j]),
      .term     (terms[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_r <= '0;
    end else if (adv) begin
      t0_r.vld <= in_valid;
      t0_r.fs  <= in_data.frame_start;
    end
  end

  tmfd_sum #(
    .NCELL (NCELL)
  ) u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .tag_in  (t0_r),
    .terms   (terms),
    .tag_out (t3),
    .sum     (sum)
  );

  always_comb begin
    hit = sum > thr_r;
    det = (t3.fs ? 1'b0 : latch_r) | hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      latch_r     <= 1'b0;
    end else if (adv) begin
      out_valid_r <= t3.vld;
      if (t3.vld) begin
        latch_r <= det;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && t3.vld) begin
      out_data_r.correlation <= sum;
      out_data_r.hit         <= hit;
      out_data_r.detected    <= det;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_frame_clears_history: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.frame_start |=> dout[0] == '0
  ) else $error("history not cleared by frame start");

  a_hit_consistent: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.detected && (out_data.correlation > thr_r)
  ) else $error("hit flag inconsistent with threshold or detection latch");

endmodule

// ===== tb/tmfd_result_check.sv =====
module tmfd_result_check
  import tmfd_pkg::*;
#(
  parameter int TAPS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    results_pending
);

  localparam int HIST_DEPTH = TAPS - 1;

  logic signed [SUM_W-1:0] threshold;
  logic [KEY_W-1:0]        key_signs;
  logic [SAMPLE_W-1:0]     history [HIST_DEPTH];
  logic                    detect_latch;
  out_t                    expected_results [$];
  int                      errors = 0;

  initial begin
    mismatch_count = 0;
    results_pending = 0;
  end

  function automatic int correlate(input logic [SAMPLE_W-1:0] cur);
    int acc;
    int x;
    acc = 0;
    for (int k = 0; k < TAPS && k < 2 * KEY_W; k += 2) begin
      x = (k == 0) ? int'(cur) : int'(history[k-1]);
      if (key_signs[k/2]) begin
        acc += x;
      end else begin
        acc -= x;
      end
    end
    return acc;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endtask

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] cur;
    int                  acc;
    out_t                pred;
    out_t                want;
    if (!rst_n) begin
      threshold = THRESHOLD_RESET;
      key_signs = '0;
      detect_latch = 1'b0;
      foreach (history[i]) history[i] = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_THRESHOLD: threshold = cfg_wdata[SUM_W-1:0];
          REG_KEY_LOW:   key_signs[CFG_DATA_W-1:0] = cfg_wdata;
          REG_KEY_HIGH:  key_signs[KEY_W-1:CFG_DATA_W] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        cur = in_data.raw_sample[SAMPLE_LSB +: SAMPLE_W];
        if (in_data.frame_start) begin
          foreach (history[i]) history[i] = '0;
          detect_latch = 1'b0;
        end
        acc = correlate(cur);
        pred.correlation = SUM_W'(acc);
        pred.hit = acc > int'(threshold);
        if (pred.hit) begin
          detect_latch = 1'b1;
        end
        pred.detected = detect_latch;
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
          history[i] = history[i-1];
        end
        history[0] = cur;
        expected_results.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("Unexpected result transfer: correlation %0d hit %b detected %b",
                               out_data.correlation, out_data.hit, out_data.detected));
        end else begin
          want = expected_results.pop_front();
          if (out_data.correlation !== want.correlation || out_data.hit !== want.hit ||
              out_data.detected !== want.detected) begin
            flag_error($sformatf(
                "Result mismatch: correlation %0d/%0d hit %b/%b detected %b/%b (expected/actual)",
                want.correlation, out_data.correlation, want.hit, out_data.hit,
                want.detected, out_data.detected));
          end
        end
      end
    end
    mismatch_count <= errors;
    results_pending <= expected_results.size();
  end

endmodule

// ===== tb/ternary_matched_filter_detector_tb.sv =====
module ternary_matched_filter_detector_tb;
  import tmfd_pkg::*;

  localparam int TAPS = 256;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS = 205;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [CFG_DATA_W-1:0] ALL_ONES = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int               mismatch_count;
  int               results_pending;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               quiet_cycles = 0;
  logic [KEY_W-1:0] key_now = '0;

  ternary_matched_filter_detector #(.TAPS(TAPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  tmfd_result_check #(.TAPS(TAPS)) result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ternary_matched_filter_detector_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [15:0] place_sample(input logic [SAMPLE_W-1:0] s);
    logic [15:0] raw;
    raw = 16'($urandom);
    raw[SAMPLE_LSB +: SAMPLE_W] = s;
    return raw;
  endfunction

  task automatic send_sample(input logic [15:0] raw, input logic fs);
    in_t item;
    item.raw_sample = raw;
    item.frame_start = fs;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Upper bits of the threshold word are filled with noise; only the low 16 bits count.
  task automatic apply_settings(input logic [SUM_W-1:0] thr, input logic [CFG_DATA_W-1:0] lo,
                                input logic [CFG_DATA_W-1:0] hi, input bit poke_unused);
    write_reg(REG_THRESHOLD, {$urandom, 16'($urandom), thr});
    write_reg(REG_KEY_LOW, lo);
    write_reg(REG_KEY_HIGH, hi);
    if (poke_unused) begin
      write_reg(REG_UNUSED, {$urandom, $urandom});
    end
    cfg_we <= 1'b0;
    key_now = {hi, lo};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Most frames open with a frame start; two of four sample styles shape the samples
  // against the key, so that the sum swings to either extreme at the end of the frame.
  task automatic random_frames(input int count);
    int               sent;
    int               len;
    int               style;
    int               k;
    logic [SAMPLE_W-1:0] s;
    logic             fs;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 40);
      style = $urandom_range(3);
      for (int i = 0; i < len && sent < count; i++) begin
        k = len - 1 - i;
        case (style)
          0: s = 8'($urandom);
          1: s = (k < TAPS && k % 2 == 0) ? (key_now[k/2] ? 8'hFF : 8'h00) : 8'($urandom);
          2: s = (k < TAPS && k % 2 == 0) ? (key_now[k/2] ? 8'h00 : 8'hFF) : 8'($urandom);
          default: s = ($urandom_range(3) == 0) ? 8'($urandom) : 8'hFF;
        endcase
        fs = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(59) == 0);
        send_sample(place_sample(s), fs);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 18;
    stall_pct = 18;
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hF00F, 1'b0);
    send_sample(16'h0FF0, 1'b0);
    send_sample(16'h0FF0, 1'b1);
    send_sample(16'h0010, 1'b0);
    send_sample(16'h0800, 1'b0);
    send_sample(16'hF7FF, 1'b0);
    drain();

    apply_settings(16'd0, 64'd1, 64'd0, 1'b0);
    send_sample(16'h0FF0, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hF00F, 1'b0);
    send_sample(16'h0FF0, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h000F, 1'b0);
    send_sample(16'h0010, 1'b1);
    send_sample(16'h0FF0, 1'b0);
    send_sample(16'h0000, 1'b0);
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: apply_settings(16'h8000, ALL_ONES, 64'd0, 1'b1);
        1: apply_settings(16'd32640, ALL_ONES, ALL_ONES, 1'b0);
        2: apply_settings(16'd32639, ALL_ONES, ALL_ONES, 1'b0);
        3: apply_settings(16'(-32640), 64'd0, 64'd0, 1'b0);
        4: apply_settings(16'h7FFF, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        5: apply_settings(16'($urandom_range(8000) - 4000), {$urandom, $urandom},
                          {$urandom, $urandom}, 1'b0);
        default: apply_settings(16'(-32641), 64'd0, 64'd0, 1'b0);
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 84;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 84;
        end
        default: begin
          send_idle_pct = 18;
          stall_pct = 18;
        end
      endcase
      random_frames(PHASE_ITEMS);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("ternary_matched_filter_detector_tb OK");
    end else begin
      $display("ternary_matched_filter_detector_tb NOT OK");
    end
    $finish;
  end

endmodule
